// ===== rtl/core/rtfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfp_pkg
// Shared types, constants and helpers of the range text frame parser.
// ----------------------------------------------------------------------------
package rtfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int DIST_W   = 15;
    localparam int OFFS_W   = 3;
    localparam int HIT_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 15;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_TARGET = 2'd2;

    // reset values of the configuration registers
    localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'h3A;
    localparam logic [DIST_W-1:0] NEAR_THR_RST   = 15'd20;
    localparam logic [HIT_W-1:0]  HIT_TARGET_RST = 4'd3;

    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'h30;

    localparam logic [OFFS_W-1:0] OFFS_HUNDREDS = 3'd3;
    localparam logic [OFFS_W-1:0] OFFS_TENS     = 3'd4;
    localparam logic [OFFS_W-1:0] OFFS_UNITS    = 3'd5;
    localparam logic [OFFS_W-1:0] OFFS_MAX      = 3'd7;

    localparam logic [DIST_W-1:0] DIST_MAX = 15'd28305;

    // command codes
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_JUDGE = 1'b1;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              done;
    } t_parse_res;

    // space reads as zero, anything else as byte minus '0' modulo 256
    function automatic logic [BYTE_W-1:0] digit_of(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        d = b - DIGIT_BASE;
        if (b == CHAR_SPACE) begin
            d = '0;
        end
        return d;
    endfunction

endpackage

// ===== rtl/core/rtfp_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfp_parse
// Frame state, digit registers and distance latch for received bytes.
// ----------------------------------------------------------------------------
module rtfp_parse
    import rtfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_start_char,
    output t_parse_res        o_res
);

    logic              r_in_frame, n_in_frame;
    logic [OFFS_W-1:0] r_offset, n_offset;
    logic [BYTE_W-1:0] r_hundreds, n_hundreds;
    logic [BYTE_W-1:0] r_tens, n_tens;
    logic [BYTE_W-1:0] r_units, n_units;
    logic [DIST_W-1:0] r_last_dist;
    logic              done;
    logic [BYTE_W-1:0] digit;
    logic [DIST_W-1:0] sum;

    assign digit = digit_of(i_byte);

    // uses the digits as they stand after this byte
    assign sum = DIST_W'(n_hundreds) * DIST_W'(100)
               + DIST_W'(n_tens) * DIST_W'(10)
               + DIST_W'(n_units);

    always_comb begin
        n_in_frame  = r_in_frame;
        n_offset    = r_offset;
        n_hundreds  = r_hundreds;
        n_tens      = r_tens;
        n_units     = r_units;
        if (i_byte == i_start_char) begin
            n_in_frame = 1'b1;
            n_offset   = '0;
            n_hundreds = '0;
            n_tens     = '0;
            n_units    = '0;
        end else if (r_in_frame && (r_offset != OFFS_MAX)) begin
            n_offset = r_offset + 1'b1;
        end
        if (n_in_frame) begin
            if (n_offset == OFFS_HUNDREDS) begin
                n_hundreds = digit;
            end else if (n_offset == OFFS_TENS) begin
                n_tens = digit;
            end else if (n_offset == OFFS_UNITS) begin
                n_units = digit;
            end
        end
    end

    // close on line feed; split out so the sum sees the updated digits
    logic              c_in_frame;
    logic [OFFS_W-1:0] c_offset;
    always_comb begin
        c_in_frame = n_in_frame;
        c_offset   = n_offset;
        done       = 1'b0;
        if (i_step && n_in_frame && (i_byte == CHAR_LF)) begin
            c_in_frame  = 1'b0;
            c_offset    = '0;
            done        = 1'b1;
        end
    end

    logic [DIST_W-1:0] n_last_dist_sel;
    assign n_last_dist_sel = done ? sum : r_last_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_offset    <= '0;
            r_hundreds  <= '0;
            r_tens      <= '0;
            r_units     <= '0;
            r_last_dist <= '0;
        end else if (i_step) begin
            r_in_frame  <= c_in_frame;
            r_offset    <= c_offset;
            r_hundreds  <= n_hundreds;
            r_tens      <= n_tens;
            r_units     <= n_units;
            r_last_dist <= n_last_dist_sel;
        end
    end

    assign o_res.distance = n_last_dist_sel;
    assign o_res.done     = done;

endmodule

// ===== rtl/core/rtfp_judge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfp_judge
// Counts consecutive near judgements and flags near on reaching the target.
// ----------------------------------------------------------------------------
module rtfp_judge
    import rtfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [DIST_W-1:0] i_distance,
    input  logic [DIST_W-1:0] i_near_thr,
    input  logic [HIT_W-1:0]  i_hit_target,
    output logic              o_near
);

    logic [HIT_W-1:0] r_hit_count, n_hit_count;
    logic [HIT_W-1:0] inc;

    assign inc = r_hit_count + 1'b1;

    always_comb begin
        n_hit_count = '0;
        o_near      = 1'b0;
        if (i_distance <= i_near_thr) begin
            n_hit_count = inc;
            if (inc >= i_hit_target) begin
                n_hit_count = '0;
                o_near      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_count <= '0;
        end else if (i_step) begin
            r_hit_count <= n_hit_count;
        end
    end

endmodule

// ===== rtl/core/range_text_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_text_frame_parser
// Parses a range sensor's text frames into a distance and judges nearness.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        sink       i_in_valid/o_in_stall  i_command, i_byte_value
//  out       source     o_out_valid/i_out_stall o_distance_out, o_frame_done, o_near
//  cfg       sink       i_cfg_we               i_cfg_index, i_cfg_data
//
//  one item per cycle sustained while the output is not stalled; each result
//  passes through the input register, then the result register, after its
//  item is accepted.
//  synchronous active-low reset clears frame state, digits, distance, hit
//  count and both valid flags, and loads the config registers' reset values.
//  a stalled result holds the result register; the input register still
//  takes one more item, after which o_in_stall rises.
// ----------------------------------------------------------------------------
module range_text_frame_parser
    import rtfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic [BYTE_W-1:0]    i_byte_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DIST_W-1:0]    o_distance_out,
    output logic                 o_frame_done,
    output logic                 o_near,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic [BYTE_W-1:0] r_start_char;
    logic [DIST_W-1:0] r_near_thr;
    logic [HIT_W-1:0]  r_hit_target;

    logic              r_in_valid;
    logic              r_in_cmd;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_done;
    logic              r_out_near;

    logic       out_free;
    logic       adv;
    logic       in_acc;
    t_parse_res parse_res;
    logic       judge_near;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= START_CHAR_RST;
            r_near_thr   <= NEAR_THR_RST;
            r_hit_target <= HIT_TARGET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_CHAR: r_start_char <= i_cfg_data[BYTE_W-1:0];
                CFG_NEAR_THR:   r_near_thr   <= i_cfg_data[DIST_W-1:0];
                CFG_HIT_TARGET: r_hit_target <= i_cfg_data[HIT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_cmd  <= i_command;
            r_in_byte <= i_byte_value;
        end
    end

    rtfp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (adv && (r_in_cmd == CMD_BYTE)),
        .i_byte       (r_in_byte),
        .i_start_char (r_start_char),
        .o_res        (parse_res)
    );

    // judge sees the latched distance, which a judge item never changes
    rtfp_judge u_judge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (adv && (r_in_cmd == CMD_JUDGE)),
        .i_distance   (parse_res.distance),
        .i_near_thr   (r_near_thr),
        .i_hit_target (r_hit_target),
        .o_near       (judge_near)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_dist <= parse_res.distance;
            r_out_done <= (r_in_cmd == CMD_BYTE) && parse_res.done;
            r_out_near <= (r_in_cmd == CMD_JUDGE) && judge_near;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_distance_out = r_out_dist;
    assign o_frame_done   = r_out_done;
    assign o_near         = r_out_near;

    a_no_done_and_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_frame_done && o_near))
        else $error("frame_done and near raised together");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_out_valid)
        else $error("advanced item did not reach the result register");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> r_in_valid)
        else $error("held input item lost");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_distance_out <= DIST_MAX))
        else $error("distance out of range");

endmodule

// ===== dv/range_text_frame_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_text_frame_parser_tb
// Streams sensor bytes and judge commands through the frame parser. The
// expected distance, frame_done and near flags are worked out for every
// accepted item and compared in order with what the block returns. Runs go
// through several register settings, with random gaps and stalls on both
// channels.
// ----------------------------------------------------------------------------
module range_text_frame_parser_tb
    import rtfp_pkg::*;
;

    typedef struct {
        logic              cmd;
        logic [BYTE_W-1:0] value;
    } t_sensor_item;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              done;
        logic              near;
    } t_reading;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 i_command      = 1'b0;
    logic [BYTE_W-1:0]    i_byte_value   = '0;
    logic                 i_out_stall    = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data     = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [DIST_W-1:0]    o_distance_out;
    logic                 o_frame_done;
    logic                 o_near;

    range_text_frame_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_byte_value   (i_byte_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_distance_out (o_distance_out),
        .o_frame_done   (o_frame_done),
        .o_near         (o_near),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser copy used for prediction
    logic [BYTE_W-1:0] start_sel   = START_CHAR_RST;
    logic [DIST_W-1:0] thr_sel     = NEAR_THR_RST;
    logic [HIT_W-1:0]  hits_sel    = HIT_TARGET_RST;
    logic              frame_open  = 1'b0;
    logic [OFFS_W-1:0] frame_pos   = '0;
    logic [BYTE_W-1:0] hund_digit  = '0;
    logic [BYTE_W-1:0] tens_digit  = '0;
    logic [BYTE_W-1:0] units_digit = '0;
    logic [DIST_W-1:0] held_dist   = '0;
    logic [HIT_W-1:0]  near_run    = '0;

    t_sensor_item sensor_stream[$];
    t_reading     pending_readings[$];
    int           errors        = 0;
    int           queued_items  = 0;
    int           readings_seen = 0;
    int           gap_left      = 0;
    bit           quiet         = 1'b0;

    function automatic t_reading advance_parser(input t_sensor_item it);
        t_reading          r;
        logic [BYTE_W-1:0] weight;
        int                sum;
        r.done = 1'b0;
        r.near = 1'b0;
        weight = (it.value == CHAR_SPACE) ? 8'd0 : it.value - DIGIT_BASE;
        if (it.cmd == CMD_BYTE) begin
            if (it.value == start_sel) begin
                frame_open  = 1'b1;
                frame_pos   = '0;
                hund_digit  = '0;
                tens_digit  = '0;
                units_digit = '0;
            end else if (frame_open && frame_pos != OFFS_MAX) begin
                frame_pos = frame_pos + 1'b1;
            end
            if (frame_open) begin
                if (frame_pos == OFFS_HUNDREDS) begin
                    hund_digit = weight;
                end else if (frame_pos == OFFS_TENS) begin
                    tens_digit = weight;
                end else if (frame_pos == OFFS_UNITS) begin
                    units_digit = weight;
                end
                if (it.value == CHAR_LF) begin
                    frame_open = 1'b0;
                    frame_pos  = '0;
                    sum        = int'(hund_digit) * 100 + int'(tens_digit) * 10
                                 + int'(units_digit);
                    held_dist  = sum[DIST_W-1:0];
                    r.done     = 1'b1;
                end
            end
        end else begin
            if (held_dist <= thr_sel) begin
                near_run = near_run + 1'b1;
                if (near_run >= hits_sel) begin
                    near_run = '0;
                    r.near   = 1'b1;
                end
            end else begin
                near_run = '0;
            end
        end
        r.distance = held_dist;
        return r;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // sender
    always @(posedge i_clk) begin : drive
        t_sensor_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                nxt.cmd   = i_command;
                nxt.value = i_byte_value;
                pending_readings.push_back(advance_parser(nxt));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    i_in_valid <= 1'b0;
                    gap_left = gap_left - 1;
                end else if (sensor_stream.size() > 0) begin
                    nxt = sensor_stream.pop_front();
                    i_in_valid   <= 1'b1;
                    i_command    <= nxt.cmd;
                    i_byte_value <= nxt.value;
                    gap_left = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with two long hold-offs so the input side backs up
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_a     = 1'b0;
    bit hold_b     = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (!hold_a && readings_seen >= 300) begin
                hold_a    = 1'b1;
                hold_left = 80;
            end else if (!hold_b && readings_seen >= 1200) begin
                hold_b    = 1'b1;
                hold_left = 120;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left = stall_left - 1;
            end else begin
                i_out_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 99) < 15) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin : check
        t_reading want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            readings_seen <= readings_seen + 1;
            if (pending_readings.size() == 0) begin
                $error("result with nothing expected: distance_out %0d", o_distance_out);
                errors = errors + 1;
            end else begin
                want = pending_readings.pop_front();
                if (o_distance_out !== want.distance) begin
                    $error("distance_out expected %0d actual %0d",
                           want.distance, o_distance_out);
                    errors = errors + 1;
                end
                if (o_frame_done !== want.done) begin
                    $error("frame_done expected %0b actual %0b", want.done, o_frame_done);
                    errors = errors + 1;
                end
                if (o_near !== want.near) begin
                    $error("near expected %0b actual %0b", want.near, o_near);
                    errors = errors + 1;
                end
            end
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] v);
        t_sensor_item it;
        it.cmd   = CMD_BYTE;
        it.value = v;
        sensor_stream.push_back(it);
        queued_items = queued_items + 1;
    endtask

    task automatic push_judge();
        t_sensor_item it;
        it.cmd   = CMD_JUDGE;
        it.value = BYTE_W'($urandom_range(0, 255));
        sensor_stream.push_back(it);
        queued_items = queued_items + 1;
    endtask

    function automatic logic [BYTE_W-1:0] filler_byte();
        logic [BYTE_W-1:0] v;
        do begin
            v = BYTE_W'($urandom_range(0, 255));
        end while (v == start_sel || v == CHAR_LF);
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] digit_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            return CHAR_SPACE;
        end else if (r < 45) begin
            return DIGIT_BASE + BYTE_W'($urandom_range(0, 1));
        end else if (r < 90) begin
            return DIGIT_BASE + BYTE_W'($urandom_range(0, 9));
        end
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // mostly well-formed frames and judge bursts, some noise and cut frames
    task automatic queue_traffic(input int n);
        int          stop_at;
        int unsigned r;
        int          k;
        stop_at = queued_items + n;
        while (queued_items < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                push_byte(start_sel);
                push_byte(filler_byte());
                push_byte(filler_byte());
                repeat (3) push_byte(digit_char());
                k = $urandom_range(0, 3);
                repeat (k) push_byte(filler_byte());
                push_byte(CHAR_LF);
            end else if (r < 78) begin
                k = $urandom_range(1, 16);
                repeat (k) push_judge();
            end else if (r < 90) begin
                k = $urandom_range(1, 6);
                repeat (k) begin
                    if ($urandom_range(0, 1)) begin
                        push_judge();
                    end else begin
                        push_byte(BYTE_W'($urandom_range(0, 255)));
                    end
                end
            end else begin
                push_byte(start_sel);
                k = $urandom_range(0, 9);
                repeat (k) push_byte(BYTE_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) begin
                    push_byte(CHAR_LF);
                end
            end
        end
    endtask

    // sampled away from the rising edge so driver updates have settled
    task automatic wait_drained(input int limit);
        int cycles;
        cycles = 0;
        @(negedge i_clk);
        while ((sensor_stream.size() > 0 || i_in_valid || pending_readings.size() > 0)
               && cycles < limit) begin
            @(negedge i_clk);
            cycles = cycles + 1;
        end
        if (cycles >= limit) begin
            $error("results still outstanding: %0d", pending_readings.size());
            errors = errors + 1;
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_START_CHAR: start_sel = val[BYTE_W-1:0];
            CFG_NEAR_THR:   thr_sel   = val[DIST_W-1:0];
            CFG_HIT_TARGET: hits_sel  = val[HIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_setting(input logic [BYTE_W-1:0] sc, input logic [DIST_W-1:0] thr,
                               input logic [HIT_W-1:0] hits, input bit calm, input int n);
        wait_drained(200000);
        write_reg(CFG_START_CHAR, {{(CFG_DAT_W-BYTE_W){1'b0}}, sc});
        write_reg(CFG_NEAR_THR, thr);
        write_reg(CFG_HIT_TARGET, {{(CFG_DAT_W-HIT_W){1'b0}}, hits});
        quiet = calm;
        queue_traffic(n);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset settings: ignored byte outside a frame, judge at 0
        push_byte("x");
        push_judge();
        // space as hundreds, then 25
        push_byte(START_CHAR_RST);
        push_byte("R");
        push_byte("=");
        push_byte(CHAR_SPACE);
        push_byte("2");
        push_byte("5");
        push_byte(CHAR_LF);
        push_judge();
        // line feed landing on the hundreds digit
        push_byte(START_CHAR_RST);
        push_byte("a");
        push_byte("b");
        push_byte(CHAR_LF);
        // restart inside a frame, byte extremes as digits, long frame
        push_byte(START_CHAR_RST);
        push_byte(START_CHAR_RST);
        push_byte("x");
        push_byte("x");
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte("9");
        repeat (3) push_byte("m");
        push_byte(CHAR_LF);
        push_judge();
        queue_traffic(180);

        run_setting(START_CHAR_RST, 15'd32767, 4'd1, 1'b1, 220);
        run_setting(8'h00, 15'd0, 4'd15, 1'b0, 200);
        run_setting(8'hFF, 15'd150, 4'd5, 1'b0, 200);
        // start character equal to line feed
        run_setting(CHAR_LF, NEAR_THR_RST, 4'd2, 1'b0, 180);
        run_setting(CHAR_SPACE, 15'd500, 4'd4, 1'b0, 180);
        // zero hit target: every near judgement reports
        run_setting(START_CHAR_RST, 15'd999, 4'd0, 1'b0, 200);
        run_setting(START_CHAR_RST, DIST_W'($urandom_range(0, 32767)),
                    HIT_W'($urandom_range(1, 15)), 1'b0, 220);
        run_setting("#", DIST_W'($urandom_range(0, 2000)), HIT_W'($urandom_range(1, 15)),
                    1'b0, 230);

        wait_drained(200000);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
